### hw/rtl/msb_pkg.sv
package msb_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int DATA_W = 8;
  localparam int SCREEN_WIDTH_DEF = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // Source of the frame store read address.
  typedef enum logic [1:0] {
    RD_HOST  = 2'd0,
    RD_BYTE0 = 2'd1,
    RD_BYTE1 = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_sweep;
    logic    wr_byte0;
    logic    wr_byte1;
    logic    res_load;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
  } dp_status_t;

endpackage

### hw/rtl/msb_ram.sv
module msb_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/msb_ctrl.sv
module msb_ctrl import msb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    ST_INIT  = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_CLR   = 8'b0000_0100,
    ST_RD0   = 8'b0000_1000,
    ST_RMW0  = 8'b0001_0000,
    ST_RMW1  = 8'b0010_0000,
    ST_RDOUT = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   is_draw_q, is_draw_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    is_draw_d = is_draw_q;
    cmd_o = '0;
    cmd_o.rd_sel = RD_HOST;
    case (state_q)
      ST_INIT: begin
        cmd_o.wr_sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          is_draw_d = (cmd_i == CMD_DRAW);
          case (cmd_i)
            CMD_CLEAR: state_d = ST_CLR;
            CMD_DRAW:  state_d = ST_RD0;
            CMD_READ:  state_d = ST_RD0;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_CLR: begin
        cmd_o.wr_sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_DONE;
        end
      end
      ST_RD0: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = is_draw_q ? RD_BYTE0 : RD_HOST;
        state_d = is_draw_q ? ST_RMW0 : ST_RDOUT;
      end
      ST_RMW0: begin
        // The first byte is written back while the second one is fetched.
        cmd_o.wr_byte0 = 1'b1;
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = RD_BYTE1;
        state_d = ST_RMW1;
      end
      ST_RMW1: begin
        cmd_o.wr_byte1 = 1'b1;
        state_d = ST_DONE;
      end
      ST_RDOUT: begin
        cmd_o.res_load = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      out_valid_q <= 1'b0;
      is_draw_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      is_draw_q <= is_draw_d;
    end
  end

endmodule

### hw/rtl/msb_datapath.sv
module msb_datapath import msb_pkg::*; #(
  parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  output dp_status_t        status_o,
  input  logic signed [8:0] pos_x_i,
  input  logic signed [8:0] pos_y_i,
  input  logic [7:0]        pixel_bits_i,
  input  logic [7:0]        mask_bits_i,
  input  logic              use_mask_i,
  input  logic [3:0]        pixel_count_i,
  input  logic [7:0]        clip_left_i,
  input  logic [7:0]        clip_right_i,
  input  logic [9:0]        read_addr_i,
  output logic [7:0]        read_data_o
);

  localparam int ROW_BYTES = (SCREEN_WIDTH + 7) / 8;
  localparam int RB_W = $clog2(ROW_BYTES + 1);
  localparam int PROD_W = 8 + RB_W;
  localparam int IDX_W = ((PROD_W > ADDR_W) ? PROD_W : ADDR_W) + 2;
  localparam logic [RB_W-1:0] ROW_BYTES_U = RB_W'(ROW_BYTES);
  localparam logic signed [11:0] WIDTH_S = 12'(SCREEN_WIDTH);
  localparam logic [10:0] HEIGHT_U = 11'(SCREEN_HEIGHT);
  localparam logic signed [IDX_W-1:0] DEPTH_S = IDX_W'(STORE_DEPTH);

  // Captured item.
  logic signed [8:0]  x_q, y_q;
  logic [7:0]         pix_q, msk_q, cl_q, cr_q;
  logic [3:0]         cnt_q;
  logic [ADDR_W-1:0]  raddr_q;
  logic [DATA_W-1:0]  res_q, read_data_q;
  logic [ADDR_W-1:0]  sweep_q, sweep_d;

  logic [7:0]         m0, v0, m1, v1;
  logic               y_ok, en0, en1;
  logic [PROD_W-1:0]  row_base;
  logic signed [8:0]  col0;
  logic signed [IDX_W-1:0] idx0, idx1;
  logic [ADDR_W-1:0]  addr0, addr1;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0]  ram_wdata, ram_rdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= pos_x_i;
      y_q <= pos_y_i;
      pix_q <= pixel_bits_i;
      msk_q <= use_mask_i ? mask_bits_i : 8'hFF;
      cnt_q <= (pixel_count_i > 4'd8) ? 4'd8 : pixel_count_i;
      cl_q <= clip_left_i;
      cr_q <= clip_right_i;
      raddr_q <= read_addr_i;
    end
    if (cmd_i.load) begin
      res_q <= '0;
    end else if (cmd_i.res_load) begin
      res_q <= ram_rdata;
    end
    if (cmd_i.out_load) begin
      read_data_q <= res_q;
    end
  end

  // Per-pixel gating and placement into the two bytes the group can touch.
  always_comb begin
    logic signed [11:0] px;
    logic [3:0]         slot;
    logic               en;
    m0 = '0;
    v0 = '0;
    m1 = '0;
    v1 = '0;
    for (int i = 0; i < 8; i++) begin
      px = 12'(x_q) + 12'(i);
      slot = {1'b0, x_q[2:0]} + 4'(i);
      en = (4'(i) < cnt_q) && msk_q[7-i] &&
           (px >= $signed({4'b0000, cl_q})) && (px < $signed({4'b0000, cr_q})) &&
           !px[11] && (px < WIDTH_S);
      if (en) begin
        if (slot[3]) begin
          m1[px[2:0]] = 1'b1;
          v1[px[2:0]] = pix_q[7-i];
        end else begin
          m0[px[2:0]] = 1'b1;
          v0[px[2:0]] = pix_q[7-i];
        end
      end
    end
  end

  assign y_ok = !y_q[8] && ({3'b000, y_q[7:0]} < HEIGHT_U);
  assign row_base = PROD_W'(y_q[7:0] * ROW_BYTES_U);
  assign col0 = x_q >>> 3;
  assign idx0 = $signed({{(IDX_W-PROD_W){1'b0}}, row_base}) + IDX_W'(col0);
  assign idx1 = idx0 + IDX_W'(1);
  assign addr0 = idx0[ADDR_W-1:0];
  assign addr1 = idx1[ADDR_W-1:0];
  // A byte with a drawn pixel always has a non-negative index.
  assign en0 = (m0 != 8'h00) && y_ok && (idx0 < DEPTH_S);
  assign en1 = (m1 != 8'h00) && y_ok && (idx1 < DEPTH_S);

  always_comb begin
    ram_we = cmd_i.wr_sweep || (cmd_i.wr_byte0 && en0) || (cmd_i.wr_byte1 && en1);
    ram_waddr = sweep_q;
    ram_wdata = '0;
    if (cmd_i.wr_byte0) begin
      ram_waddr = addr0;
      ram_wdata = (ram_rdata & ~m0) | v0;
    end else if (cmd_i.wr_byte1) begin
      ram_waddr = addr1;
      ram_wdata = (ram_rdata & ~m1) | v1;
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_HOST:  ram_raddr = raddr_q;
      RD_BYTE0: ram_raddr = addr0;
      RD_BYTE1: ram_raddr = addr1;
      default:  ram_raddr = raddr_q;
    endcase
  end

  assign sweep_d = cmd_i.wr_sweep ? sweep_q + ADDR_W'(1) : sweep_q;
  assign status_o.sweep_last = (sweep_q == {ADDR_W{1'b1}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else begin
      sweep_q <= sweep_d;
    end
  end

  msb_ram #(
    .Width(DATA_W),
    .Depth(STORE_DEPTH)
  ) u_frame_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign read_data_o = read_data_q;

endmodule

### hw/rtl/masked_sprite_blitter_unit.sv
// A draw item steps through the states RD0, RMW0, RMW1 and DONE before the next word is taken;
// two read-modify-write passes over the single frame store set that. A read steps through RD0,
// RDOUT and DONE, an unused command goes straight to DONE, and a clear sweeps the store in CLR,
// one byte a cycle. After reset the block sweeps the 1024-byte frame store to zero before taking
// its first word. The output register lets the next word in while a result waits.
module masked_sprite_blitter_unit import msb_pkg::*; #(
  parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic signed [8:0] pos_x_i,
  input  logic signed [8:0] pos_y_i,
  input  logic [7:0]        pixel_bits_i,
  input  logic [7:0]        mask_bits_i,
  input  logic              use_mask_i,
  input  logic [3:0]        pixel_count_i,
  input  logic [7:0]        clip_left_i,
  input  logic [7:0]        clip_right_i,
  input  logic [9:0]        read_addr_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        read_data_o
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  msb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  msb_datapath #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .status_o     (dp_status),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pixel_bits_i (pixel_bits_i),
    .mask_bits_i  (mask_bits_i),
    .use_mask_i   (use_mask_i),
    .pixel_count_i(pixel_count_i),
    .clip_left_i  (clip_left_i),
    .clip_right_i (clip_right_i),
    .read_addr_i  (read_addr_i),
    .read_data_o  (read_data_o)
  );

endmodule

### tb/msb_frame_checker.sv
module msb_frame_checker import msb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        cmd_i,
  input  logic signed [8:0] pos_x_i,
  input  logic signed [8:0] pos_y_i,
  input  logic [7:0]        pixel_bits_i,
  input  logic [7:0]        mask_bits_i,
  input  logic              use_mask_i,
  input  logic [3:0]        pixel_count_i,
  input  logic [7:0]        clip_left_i,
  input  logic [7:0]        clip_right_i,
  input  logic [9:0]        read_addr_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [7:0]        read_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_BYTES = (SCREEN_WIDTH_DEF + 7) / 8;

  logic [7:0] frame_copy [STORE_DEPTH];
  logic [7:0] expected_bytes [$];

  // Applies one accepted word to the local frame copy and returns the byte it should read.
  task automatic apply_word(output logic [7:0] rd_byte);
    int count;
    int px;
    int py;
    int idx;
    int i;
    bit in_span;
    bit opaque;
    rd_byte = '0;
    if (cmd_i == CMD_CLEAR) begin
      for (idx = 0; idx < STORE_DEPTH; idx++) frame_copy[idx] = '0;
    end else if (cmd_i == CMD_DRAW) begin
      count = (pixel_count_i > 4'd8) ? 8 : int'(pixel_count_i);
      py = int'(pos_y_i);
      for (i = 0; i < count; i++) begin
        px = int'(pos_x_i) + i;
        in_span = (px >= int'(clip_left_i)) && (px < int'(clip_right_i));
        opaque = !use_mask_i || mask_bits_i[7 - i];
        idx = py * ROW_BYTES + px / 8;
        if (in_span && opaque && px >= 0 && px < SCREEN_WIDTH_DEF && py >= 0 &&
            py < SCREEN_HEIGHT_DEF && idx < STORE_DEPTH) begin
          frame_copy[idx][px % 8] = pixel_bits_i[7 - i];
        end
      end
    end else if (cmd_i == CMD_READ) begin
      rd_byte = frame_copy[read_addr_i];
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [7:0] want;
    int a;
    if (!rst_ni) begin
      for (a = 0; a < STORE_DEPTH; a++) frame_copy[a] = '0;
      expected_bytes.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t ns: read_data word 0x%02h arrived with nothing expected",
                     $time, read_data_i);
          end
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_bytes.pop_front();
          if (read_data_i !== want) begin
            if (fail_count_o < 10) begin
              $display("%0t ns: read_data mismatch, expected 0x%02h, got 0x%02h",
                       $time, want, read_data_i);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_word(want);
        expected_bytes.push_back(want);
      end
      pending_o <= expected_bytes.size();
    end
  end

endmodule

### tb/masked_sprite_blitter_unit_test.sv
module masked_sprite_blitter_unit_test;
  import msb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_BYTES = (SCREEN_WIDTH_DEF + 7) / 8;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1000;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [8:0] x;
    logic [8:0] y;
    logic [7:0] pix;
    logic [7:0] msk;
    logic       use_mask;
    logic [3:0] count;
    logic [7:0] clip_l;
    logic [7:0] clip_r;
    logic [9:0] addr;
  } blit_word_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] cmd = '0;
  logic [8:0] pos_x = '0;
  logic [8:0] pos_y = '0;
  logic [7:0] pixel_bits = '0;
  logic [7:0] mask_bits = '0;
  logic       use_mask = 1'b0;
  logic [3:0] pixel_count = '0;
  logic [7:0] clip_left = '0;
  logic [7:0] clip_right = '0;
  logic [9:0] read_addr = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] read_data;
  int         fail_count;
  int         pending;
  int         quiet_cycles = 0;
  bit         send_burst = 1'b0;
  int         last_x = 0;
  int         last_y = 0;

  masked_sprite_blitter_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .pos_x_i       (pos_x),
    .pos_y_i       (pos_y),
    .pixel_bits_i  (pixel_bits),
    .mask_bits_i   (mask_bits),
    .use_mask_i    (use_mask),
    .pixel_count_i (pixel_count),
    .clip_left_i   (clip_left),
    .clip_right_i  (clip_right),
    .read_addr_i   (read_addr),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .read_data_o   (read_data)
  );

  msb_frame_checker u_frame_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .cmd_i         (cmd),
    .pos_x_i       (pos_x),
    .pos_y_i       (pos_y),
    .pixel_bits_i  (pixel_bits),
    .mask_bits_i   (mask_bits),
    .use_mask_i    (use_mask),
    .pixel_count_i (pixel_count),
    .clip_left_i   (clip_left),
    .clip_right_i  (clip_right),
    .read_addr_i   (read_addr),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .read_data_i   (read_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic blit_word_t draw_word(int x, int y, int pix, int msk, bit um, int cnt,
                                           int cl, int cr);
    blit_word_t w;
    w = '0;
    w.cmd = CMD_DRAW;
    w.x = 9'(x);
    w.y = 9'(y);
    w.pix = 8'(pix);
    w.msk = 8'(msk);
    w.use_mask = um;
    w.count = 4'(cnt);
    w.clip_l = 8'(cl);
    w.clip_r = 8'(cr);
    return w;
  endfunction

  function automatic blit_word_t read_word(int addr);
    blit_word_t w;
    w = '0;
    w.cmd = CMD_READ;
    w.addr = 10'(addr);
    return w;
  endfunction

  function automatic blit_word_t random_word();
    blit_word_t w;
    logic [95:0] raw;
    int r;
    int x;
    int y;
    int cl;
    int cr;
    int cnt;
    raw = {$urandom, $urandom, $urandom};
    r = $urandom_range(0, 199);
    if (r < 2) begin
      w = '0;
      w.cmd = CMD_CLEAR;
    end else if (r < 8) begin
      w = raw[$bits(blit_word_t)-1:0];
      w.cmd = CMD_UNUSED;
    end else if (r < 128) begin
      if ($urandom_range(0, 9) == 0) begin
        // Full-range fields: far off-screen positions, odd counts and clip bounds.
        w = raw[$bits(blit_word_t)-1:0];
        w.cmd = CMD_DRAW;
      end else begin
        x = int'($urandom_range(0, 143)) - 8;
        y = int'($urandom_range(0, 67)) - 2;
        cl = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 64));
        cr = ($urandom_range(0, 2) == 0) ? 128 : int'($urandom_range(cl, 128));
        cnt = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 15))
                                          : int'($urandom_range(1, 8));
        w = draw_word(x, y, $urandom_range(0, 255), $urandom_range(0, 255),
                      1'($urandom_range(0, 1)), cnt, cl, cr);
        last_x = x;
        last_y = y;
      end
    end else begin
      if ($urandom_range(0, 9) < 6) begin
        // Read back near the most recent draw so that written bytes get checked.
        x = last_x + int'($urandom_range(0, 7));
        x = (x < 0) ? 0 : (x > SCREEN_WIDTH_DEF - 1) ? SCREEN_WIDTH_DEF - 1 : x;
        y = (last_y < 0) ? 0 : (last_y > SCREEN_HEIGHT_DEF - 1) ? SCREEN_HEIGHT_DEF - 1
                                                                 : last_y;
        w = read_word(y * ROW_BYTES + x / 8);
      end else begin
        w = read_word($urandom_range(0, STORE_DEPTH - 1));
      end
    end
    return w;
  endfunction

  task automatic offer_word(input blit_word_t w);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= w.cmd;
    pos_x <= w.x;
    pos_y <= w.y;
    pixel_bits <= w.pix;
    mask_bits <= w.msk;
    use_mask <= w.use_mask;
    pixel_count <= w.count;
    clip_left <= w.clip_l;
    clip_right <= w.clip_r;
    read_addr <= w.addr;
    do @(posedge clk); while (!in_ready);
  endtask

  // The first edge is skipped because the pending count is registered behind the input handshake.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : word_source
    blit_word_t w;
    int k;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    offer_word(read_word(0));
    offer_word(read_word(STORE_DEPTH - 1));
    offer_word(draw_word(0, 0, 'hFF, 'h00, 1'b0, 8, 0, 128));
    offer_word(read_word(0));
    // Crosses the right screen edge; only the first four pixels land.
    offer_word(draw_word(124, 63, 'hAA, 'hF0, 1'b1, 8, 0, 128));
    offer_word(read_word(63 * ROW_BYTES + 15));
    // Starts left of the screen with an oversized count.
    offer_word(draw_word(-3, 1, 'hFF, 'h00, 1'b0, 15, 0, 128));
    offer_word(read_word(ROW_BYTES));
    offer_word(draw_word(-256, -256, 'hFF, 'hFF, 1'b0, 8, 0, 255));
    offer_word(draw_word(255, 255, 'hFF, 'hFF, 1'b0, 8, 0, 255));
    offer_word(draw_word(8, 64, 'hFF, 'hFF, 1'b0, 8, 0, 128));
    offer_word(draw_word(8, 2, 'hFF, 'hFF, 1'b0, 0, 0, 128));
    offer_word(draw_word(8, 2, 'hFF, 'hFF, 1'b0, 8, 20, 20));
    offer_word(draw_word(8, 2, 'hFF, 'hFF, 1'b0, 8, 255, 0));
    offer_word(read_word(2 * ROW_BYTES + 1));
    // White pixels through a mask punch a hole into the black byte at the origin.
    offer_word(draw_word(0, 0, 'h00, 'h3C, 1'b1, 8, 0, 128));
    offer_word(read_word(0));
    offer_word(draw_word(0, 3, 'hFF, 'h00, 1'b0, 8, 4, 6));
    offer_word(read_word(3 * ROW_BYTES));
    w = draw_word(0, 0, 'hFF, 'hFF, 1'b1, 8, 0, 128);
    w.cmd = CMD_UNUSED;
    w.addr = 10'h3FF;
    offer_word(w);
    offer_word(draw_word(120, 5, 'hFF, 'h00, 1'b0, 8, 0, 255));
    offer_word(read_word(5 * ROW_BYTES + 15));
    w = '0;
    w.cmd = CMD_CLEAR;
    offer_word(w);
    offer_word(read_word(0));

    for (k = 0; k < RANDOM_WORDS; k++) begin
      if (k == RANDOM_WORDS / 2) drain_results();
      offer_word(random_word());
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    int gap;
    int taken;
    bit burst;
    taken = 0;
    burst = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 3);
      // A long hold-off lets the block back up until it stalls its input.
      if (taken == 300 || taken == 750) gap = 80;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
